FILE: rtl/swf_pkg.sv
// ----------------------------------------------------------------------------
// SIREN waveshaper package
// Shared sizes, types, table codes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package swf_pkg;

  // Network sizes. The sine table depth is a power of two.
  localparam int HIDDEN_UNITS     = 64;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int WEIGHT_BITS      = 18;

  // Derived widths.
  localparam int HU_W    = $clog2(HIDDEN_UNITS);
  localparam int MAT_N   = HIDDEN_UNITS * HIDDEN_UNITS;
  localparam int MAT_W   = $clog2(MAT_N);
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W   = DEPTH_W + 2;
  localparam int PHASE_W = 36;
  localparam int ACT_W   = 18;
  localparam int SAMPLE_W = 24;
  localparam int SCALE_W  = 24;
  localparam int IN_W_W   = 18;
  localparam int INDEX_W  = 12;
  localparam int ACC_W    = WEIGHT_BITS + ACT_W + 1 + HU_W;
  localparam int PRE_W    = ACC_W - 10;
  localparam int L1_PROD_W = WEIGHT_BITS + SAMPLE_W;
  localparam int MAC_PROD_W = WEIGHT_BITS + ACT_W;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_SECOND = 2'd1;
  localparam logic [1:0] REG_THIRD  = 2'd2;
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 24'sd312911;

  // Coefficient table codes.
  localparam logic [2:0] TBL_IN_W  = 3'd0;
  localparam logic [2:0] TBL_IN_B  = 3'd1;
  localparam logic [2:0] TBL_MID_W = 3'd2;
  localparam logic [2:0] TBL_MID_B = 3'd3;
  localparam logic [2:0] TBL_UP_W  = 3'd4;
  localparam logic [2:0] TBL_UP_B  = 3'd5;
  localparam logic [2:0] TBL_OUT_W = 3'd6;
  localparam logic [2:0] TBL_OUT_B = 3'd7;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [ACT_W-1:0]       act_t;
  typedef logic signed [PRE_W-1:0]       pre_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [SCALE_W-1:0]     scale_t;
  typedef logic signed [SAMPLE_W-1:0]    sample_t;

  typedef struct packed {
    scale_t first_scale;
    scale_t second_scale;
    scale_t third_scale;
  } cfg_t;

  // A classified input item as held in the queue.
  typedef struct packed {
    logic               is_write;
    logic               wr_ok;
    logic [2:0]         table_select;
    logic [INDEX_W-1:0] entry_index;
    weight_t            weight;
    sample_t            sample;
    logic               last;
  } item_t;

  // Quarter-wave sine table, Q1.16, built at elaboration.
  typedef logic [16:0] quarter_t [0:SINE_TABLE_DEPTH];

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Divs [1:12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  function automatic quarter_t build_quarter();
    quarter_t q;
    longint   a;
    longint   a2;
    longint   term;
    longint   sum;
    longint   r;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      a    = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
      a2   = (a * a) >>> 30;
      term = a;
      sum  = a;
      // Taylor series of the sine, twelve terms past the first.
      for (int n = 1; n <= 12; n++) begin
        term = -(term * a2 / 64'sd1073741824);
        term = term / Divs[n];
        sum  = sum + term;
      end
      if (sum < 0) sum = 0;
      r = (sum + 8192) >>> 14;
      if (r > 65536) r = 65536;
      q[i] = 17'(r);
    end
    return q;
  endfunction

  localparam quarter_t QUARTER = build_quarter();

endpackage

FILE: rtl/swf_in_if.sv
// ----------------------------------------------------------------------------
// SIREN waveshaper input channel
// Valid/ready channel carrying one sample or one coefficient write.
// ----------------------------------------------------------------------------
interface swf_in_if import swf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [2:0]         table_select;
  logic [INDEX_W-1:0] entry_index;
  logic signed [IN_W_W-1:0] weight_value;
  sample_t            sample_in;
  logic               last_in;

  modport source (output valid, kind, table_select, entry_index, weight_value,
                  sample_in, last_in, input ready);
  modport sink (input valid, kind, table_select, entry_index, weight_value,
                sample_in, last_in, output ready);
endinterface

FILE: rtl/swf_out_if.sv
// ----------------------------------------------------------------------------
// SIREN waveshaper output channel
// Valid/ready channel carrying one output sample.
// ----------------------------------------------------------------------------
interface swf_out_if import swf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink (input valid, sample_out, last_out, output ready);
endinterface

FILE: rtl/swf_front.sv
// ----------------------------------------------------------------------------
// SIREN waveshaper front part
// Accepts input items, checks write ranges and queues them for the back part.
// ----------------------------------------------------------------------------
module swf_front import swf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  swf_in_if.sink in_ch,
  output item_t  item,
  output logic   item_valid,
  input  logic   item_pop
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  item_t              incoming;
  logic               push;

  // Classify the incoming item and check the write index against its table.
  always_comb begin
    incoming.is_write     = in_ch.kind;
    incoming.table_select = in_ch.table_select;
    incoming.entry_index  = in_ch.entry_index;
    incoming.weight       = weight_t'(in_ch.weight_value);
    incoming.sample       = in_ch.sample_in;
    incoming.last         = in_ch.last_in;
    case (in_ch.table_select)
      TBL_MID_W, TBL_UP_W: incoming.wr_ok = 32'(in_ch.entry_index) < MAT_N;
      TBL_OUT_B:           incoming.wr_ok = in_ch.entry_index == '0;
      default:             incoming.wr_ok = 32'(in_ch.entry_index) < HIDDEN_UNITS;
    endcase
  end

  assign in_ch.ready = count != QCNT_W'(QUEUE_DEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = count != '0;
  assign item        = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= incoming;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !item_pop) count <= count + 1'b1;
      else if (!push && item_pop) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/swf_sine.sv
// ----------------------------------------------------------------------------
// SIREN waveshaper sine unit
// Three-stage pipeline: phase multiply, quarter-wave lookup, quadrant sign.
// ----------------------------------------------------------------------------
module swf_sine import swf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  pre_t   pre,
  input  scale_t scale,
  output logic   out_valid,
  output act_t   act
);

  logic [PHASE_W-1:0] phase;
  logic               phase_valid;
  logic [IDX_W-1:0]   idx;
  logic [1:0]         quad;
  logic [DEPTH_W:0]   rom_addr;
  logic [16:0]        rom_q;
  logic               neg;
  logic               rom_valid;

  // Only the fractional turns of the phase are kept.
  always_ff @(posedge clk) begin
    phase <= PHASE_W'(scale * pre);
  end

  // Quadrant and offset into the quarter-wave table.
  always_comb begin
    idx  = phase[PHASE_W-1 -: IDX_W];
    quad = idx[IDX_W-1 -: 2];
    if (quad[0]) begin
      rom_addr = (DEPTH_W+1)'(SINE_TABLE_DEPTH) - {1'b0, idx[DEPTH_W-1:0]};
    end else begin
      rom_addr = {1'b0, idx[DEPTH_W-1:0]};
    end
  end

  // Table lookup with registered read data.
  always_ff @(posedge clk) begin
    rom_q <= QUARTER[rom_addr];
    neg   <= quad[1];
  end

  // Apply the sign of the lower half wave.
  always_ff @(posedge clk) begin
    if (neg) act <= -act_t'({1'b0, rom_q});
    else act <= act_t'({1'b0, rom_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_valid <= 1'b0;
      rom_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      phase_valid <= in_valid;
      rom_valid   <= phase_valid;
      out_valid   <= rom_valid;
    end
  end

endmodule

FILE: rtl/swf_back.sv
// ----------------------------------------------------------------------------
// SIREN waveshaper back part
// Holds the coefficient tables and runs the network one multiply a cycle while a row issues.
// ----------------------------------------------------------------------------
module swf_back import swf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_pop,
  input  cfg_t        cfg,
  swf_out_if.source   out_ch
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_L1_RD    = 11'b00000000010,
    S_L1_MUL   = 11'b00000000100,
    S_L1_PRE   = 11'b00000001000,
    S_L1_WAIT  = 11'b00000010000,
    S_ROW_INIT = 11'b00000100000,
    S_ROW_LOAD = 11'b00001000000,
    S_MAC      = 11'b00010000000,
    S_PRE      = 11'b00100000000,
    S_DN_WAIT  = 11'b01000000000,
    S_OUT      = 11'b10000000000
  } state_t;

  localparam logic [1:0] LAY_MID = 2'd0;
  localparam logic [1:0] LAY_UP  = 2'd1;
  localparam logic [1:0] LAY_OUT = 2'd2;
  localparam logic signed [ACC_W-8:0] SAT_HI = (ACC_W-7)'(8388607);
  localparam logic signed [ACC_W-8:0] SAT_LO = -(ACC_W-7)'(8388608);

  state_t             state;
  logic [1:0]         layer;
  logic [HU_W-1:0]    row;
  logic [HU_W-1:0]    col;
  logic [MAT_W-1:0]   mat_addr;
  logic               issuing;
  logic               d1;
  logic               d2;
  sample_t            x;
  logic               last;
  logic signed [L1_PROD_W-1:0]  prod1;
  logic signed [MAC_PROD_W-1:0] prod;
  acc_t               acc;
  logic               sin_go;
  pre_t               sin_pre;
  scale_t             sin_scale;
  logic               sin_ov;
  act_t               sin_act;

  // Coefficient and activation memories.
  weight_t iw_mem [HIDDEN_UNITS];
  weight_t ib_mem [HIDDEN_UNITS];
  weight_t mb_mem [HIDDEN_UNITS];
  weight_t ub_mem [HIDDEN_UNITS];
  weight_t ow_mem [HIDDEN_UNITS];
  weight_t mw_mem [MAT_N];
  weight_t uw_mem [MAT_N];
  weight_t ob;
  act_t    act0 [HIDDEN_UNITS];
  act_t    act1 [HIDDEN_UNITS];

  weight_t iw_q, ib_q, mb_q, ub_q, ow_q, mw_q, uw_q;
  act_t    a0_q, a1_q;
  weight_t w_cur;
  weight_t bias_cur;
  act_t    a_cur;
  logic    wr_go;
  logic    act_we0;
  logic    act_we1;
  logic [HU_W-1:0] vec_idx;
  logic [MAT_W-1:0] mat_idx;
  logic signed [ACC_W:0]   rnd;
  logic signed [ACC_W-8:0] y;
  sample_t                 y_sat;

  assign item_pop = (state == S_IDLE) && item_valid;
  assign wr_go    = item_pop && item.is_write && item.wr_ok;
  assign vec_idx  = item.entry_index[HU_W-1:0];
  assign mat_idx  = MAT_W'(item.entry_index);
  assign act_we0  = sin_ov && ((state == S_L1_WAIT) ||
                               (state == S_DN_WAIT && layer == LAY_UP));
  assign act_we1  = sin_ov && (state == S_DN_WAIT) && (layer == LAY_MID);

  // Table writes.
  always_ff @(posedge clk) begin
    if (wr_go) begin
      case (item.table_select)
        TBL_IN_W:  iw_mem[vec_idx] <= item.weight;
        TBL_IN_B:  ib_mem[vec_idx] <= item.weight;
        TBL_MID_W: mw_mem[mat_idx] <= item.weight;
        TBL_MID_B: mb_mem[vec_idx] <= item.weight;
        TBL_UP_W:  uw_mem[mat_idx] <= item.weight;
        TBL_UP_B:  ub_mem[vec_idx] <= item.weight;
        TBL_OUT_W: ow_mem[vec_idx] <= item.weight;
        default:   ob <= item.weight;
      endcase
    end
    if (act_we0) act0[row] <= sin_act;
    if (act_we1) act1[row] <= sin_act;
  end

  // Registered reads at the current unit, row and column.
  always_ff @(posedge clk) begin
    iw_q <= iw_mem[row];
    ib_q <= ib_mem[row];
    mb_q <= mb_mem[row];
    ub_q <= ub_mem[row];
    ow_q <= ow_mem[col];
    mw_q <= mw_mem[mat_addr];
    uw_q <= uw_mem[mat_addr];
    a0_q <= act0[col];
    a1_q <= act1[col];
  end

  // Operand selection for the current layer.
  always_comb begin
    case (layer)
      LAY_MID: begin
        w_cur = mw_q;
        bias_cur = mb_q;
        a_cur = a0_q;
      end
      LAY_UP: begin
        w_cur = uw_q;
        bias_cur = ub_q;
        a_cur = a1_q;
      end
      default: begin
        w_cur = ow_q;
        bias_cur = ob;
        a_cur = a0_q;
      end
    endcase
  end

  // Rounding and saturation of the output unit.
  always_comb begin
    rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(128);
    y   = (ACC_W-7)'(rnd >>> 8);
    if (y > SAT_HI) y_sat = sample_t'(SAT_HI);
    else if (y < SAT_LO) y_sat = sample_t'(SAT_LO);
    else y_sat = sample_t'(y);
  end

  // Multiply-accumulate datapath.
  always_ff @(posedge clk) begin
    prod1 <= iw_q * x;
    if (d1) prod <= w_cur * a_cur;
    if (state == S_ROW_LOAD) acc <= acc_t'(bias_cur) <<< 16;
    else if (d2) acc <= acc + acc_t'(prod);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      layer        <= LAY_MID;
      row          <= '0;
      col          <= '0;
      mat_addr     <= '0;
      issuing      <= 1'b0;
      d1           <= 1'b0;
      d2           <= 1'b0;
      sin_go       <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      sin_go <= 1'b0;
      d1     <= 1'b0;
      d2     <= d1;
      if (out_ch.valid && out_ch.ready && state != S_OUT) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid && !item.is_write) begin
            x     <= item.sample;
            last  <= item.last;
            row   <= '0;
            state <= S_L1_RD;
          end
        end
        S_L1_RD: state <= S_L1_MUL;
        S_L1_MUL: state <= S_L1_PRE;
        S_L1_PRE: begin
          // First layer pre-activation from one weight, its bias and the sample.
          sin_pre   <= pre_t'(prod1 >>> 16) + (pre_t'(ib_q) <<< 6);
          sin_scale <= cfg.first_scale;
          sin_go    <= 1'b1;
          state     <= S_L1_WAIT;
        end
        S_L1_WAIT: begin
          if (sin_ov) begin
            if (row == HU_W'(HIDDEN_UNITS - 1)) begin
              row      <= '0;
              layer    <= LAY_MID;
              mat_addr <= '0;
              state    <= S_ROW_INIT;
            end else begin
              row   <= row + 1'b1;
              state <= S_L1_RD;
            end
          end
        end
        S_ROW_INIT: state <= S_ROW_LOAD;
        S_ROW_LOAD: begin
          col     <= '0;
          issuing <= 1'b1;
          state   <= S_MAC;
        end
        S_MAC: begin
          // Issue one column a cycle, then let the pipeline drain.
          if (issuing) begin
            d1       <= 1'b1;
            mat_addr <= mat_addr + 1'b1;
            if (col == HU_W'(HIDDEN_UNITS - 1)) issuing <= 1'b0;
            else col <= col + 1'b1;
          end else if (!d1 && !d2) begin
            state <= (layer == LAY_OUT) ? S_OUT : S_PRE;
          end
        end
        S_PRE: begin
          sin_pre   <= pre_t'(acc >>> 10);
          sin_scale <= (layer == LAY_MID) ? cfg.second_scale : cfg.third_scale;
          sin_go    <= 1'b1;
          state     <= S_DN_WAIT;
        end
        S_DN_WAIT: begin
          if (sin_ov) begin
            state <= S_ROW_INIT;
            if (row == HU_W'(HIDDEN_UNITS - 1)) begin
              row      <= '0;
              mat_addr <= '0;
              layer    <= (layer == LAY_MID) ? LAY_UP : LAY_OUT;
            end else begin
              row <= row + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid      <= 1'b1;
            out_ch.sample_out <= y_sat;
            out_ch.last_out   <= last;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  swf_sine u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sin_go),
    .pre       (sin_pre),
    .scale     (sin_scale),
    .out_valid (sin_ov),
    .act       (sin_act)
  );

endmodule

FILE: rtl/siren_mlp_waveshaper_core.sv
// ----------------------------------------------------------------------------
// SIREN waveshaper core
// Per-sample sine-activated network used as an audio nonlinearity.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer
//  in_ch     in         one sample or one coefficient write
//  out_ch    out        one output sample per input sample
//  APB       in         phase scale registers at 0x0, 0x4, 0x8
//
//  The back part stores a coefficient write without leaving its idle state.
//  The time a sample takes is set by the single multiply-accumulate unit
//  walking both weight matrices and the wait on the sine pipeline for every unit.
//  Reset is synchronous; the tables hold no reset value and must be loaded.
//  A two-entry queue lets input transfers continue while the output stalls.
// ----------------------------------------------------------------------------
module siren_mlp_waveshaper_core import swf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  swf_in_if.sink                in_ch,
  swf_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_pop;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Phase scale registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_scale  <= SCALE_RESET;
      cfg.second_scale <= SCALE_RESET;
      cfg.third_scale  <= SCALE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FIRST:  cfg.first_scale  <= scale_t'(pwdata[SCALE_W-1:0]);
        REG_SECOND: cfg.second_scale <= scale_t'(pwdata[SCALE_W-1:0]);
        REG_THIRD:  cfg.third_scale  <= scale_t'(pwdata[SCALE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Register read back, sign extended.
  always_comb begin
    case (paddr[3:2])
      REG_FIRST:  prdata = CFG_DATA_W'(cfg.first_scale);
      REG_SECOND: prdata = CFG_DATA_W'(cfg.second_scale);
      REG_THIRD:  prdata = CFG_DATA_W'(cfg.third_scale);
      default:    prdata = '0;
    endcase
  end

  swf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  swf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .cfg        (cfg),
    .out_ch     (out_ch)
  );

endmodule

FILE: sim/siren_mlp_waveshaper_core_test_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIREN waveshaper testbench channel bundle
// Holds the record type for the input transfers that the test drives.
// ----------------------------------------------------------------------------
// The channel interfaces themselves live with the RTL (swf_in_if, swf_out_if).
// This file holds the small record type the test uses to describe one
// transfer on the input channel.
package swf_test_pkg;
  import swf_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [2:0]               table_select;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [IN_W_W-1:0] weight_value;
    sample_t                  sample_in;
    logic                     last_in;
  } in_item_t;
endpackage

FILE: sim/siren_mlp_waveshaper_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIREN waveshaper core test
// Loads every coefficient table, then streams directed and random samples and
// coefficient rewrites under several phase scale settings and idle patterns,
// predicting each output sample in a bit-exact model of the network.
// ----------------------------------------------------------------------------
module siren_mlp_waveshaper_core_test;
  import swf_pkg::*;
  import swf_test_pkg::*;

  // Bit-exact predictor of the network, with its own tables and scales.
  class waveshaper_predictor;
    int      in_w[HIDDEN_UNITS];
    int      in_b[HIDDEN_UNITS];
    int      mid_w[MAT_N];
    int      mid_b[HIDDEN_UNITS];
    int      up_w[MAT_N];
    int      up_b[HIDDEN_UNITS];
    int      out_w[HIDDEN_UNITS];
    int      out_b;
    longint  scale_first;
    longint  scale_second;
    longint  scale_third;
    int      quarter_wave[0:SINE_TABLE_DEPTH];
    sample_t expected_samples[$];
    logic    expected_lasts[$];
    int      mismatches;
    int      samples_checked;
    int      writes_seen;

    function new();
      longint a, a2, term, sum, r;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
        a    = 64'sd1686629713 * i / SINE_TABLE_DEPTH;
        a2   = (a * a) >>> 30;
        term = a;
        sum  = a;
        // Odd Taylor terms of the sine at Q.30.
        for (int n = 1; n <= 12; n++) begin
          term = -(term * a2 / 64'sd1073741824);
          term = term / ((2 * n) * (2 * n + 1));
          sum  = sum + term;
        end
        if (sum < 0) sum = 0;
        r = (sum + 8192) >>> 14;
        if (r > 65536) r = 65536;
        quarter_wave[i] = int'(r);
      end
      scale_first  = SCALE_RESET;
      scale_second = SCALE_RESET;
      scale_third  = SCALE_RESET;
      mismatches = 0;
      samples_checked = 0;
      writes_seen = 0;
    endfunction

    function void set_scale(logic [1:0] idx, scale_t value);
      case (idx)
        REG_FIRST:  scale_first  = value;
        REG_SECOND: scale_second = value;
        REG_THIRD:  scale_third  = value;
        default: ;
      endcase
    endfunction

    // Only the fractional turn survives; the top two index bits pick the quadrant.
    function int sine_at(longint scale, longint pre);
      logic [63:0] turns;
      logic [11:0] idx;
      int          v;
      turns = scale * pre;
      idx   = turns[35:24];
      v = idx[10] ? quarter_wave[SINE_TABLE_DEPTH - int'(idx[9:0])]
                  : quarter_wave[int'(idx[9:0])];
      return idx[11] ? -v : v;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void note_input(in_item_t it);
      int     h0[HIDDEN_UNITS];
      int     h1[HIDDEN_UNITS];
      int     h2[HIDDEN_UNITS];
      int     w;
      int     e;
      longint acc;
      longint x;
      w = int'(it.weight_value);
      e = int'(it.entry_index);
      if (it.kind == KIND_WRITE) begin
        writes_seen++;
        // Vector writes beyond the table are dropped.
        case (it.table_select)
          TBL_IN_W:  if (e < HIDDEN_UNITS) in_w[e] = w;
          TBL_IN_B:  if (e < HIDDEN_UNITS) in_b[e] = w;
          TBL_MID_W: mid_w[e] = w;
          TBL_MID_B: if (e < HIDDEN_UNITS) mid_b[e] = w;
          TBL_UP_W:  up_w[e] = w;
          TBL_UP_B:  if (e < HIDDEN_UNITS) up_b[e] = w;
          TBL_OUT_W: if (e < HIDDEN_UNITS) out_w[e] = w;
          TBL_OUT_B: if (e == 0) out_b = w;
          default: ;
        endcase
        return;
      end
      x = longint'(it.sample_in);
      for (int r = 0; r < HIDDEN_UNITS; r++)
        h0[r] = sine_at(scale_first, ((longint'(in_w[r]) * x) >>> 16) + longint'(in_b[r]) * 64);
      for (int r = 0; r < HIDDEN_UNITS; r++) begin
        acc = longint'(mid_b[r]) * 65536;
        for (int c = 0; c < HIDDEN_UNITS; c++)
          acc += longint'(mid_w[r * HIDDEN_UNITS + c]) * h0[c];
        h1[r] = sine_at(scale_second, acc >>> 10);
      end
      for (int r = 0; r < HIDDEN_UNITS; r++) begin
        acc = longint'(up_b[r]) * 65536;
        for (int c = 0; c < HIDDEN_UNITS; c++)
          acc += longint'(up_w[r * HIDDEN_UNITS + c]) * h1[c];
        h2[r] = sine_at(scale_third, acc >>> 10);
      end
      // Linear output unit, rounded and saturated to the sample range.
      acc = longint'(out_b) * 65536;
      for (int c = 0; c < HIDDEN_UNITS; c++)
        acc += longint'(out_w[c]) * h2[c];
      acc = (acc + 128) >>> 8;
      if (acc > 8388607) acc = 8388607;
      if (acc < -8388608) acc = -8388608;
      expected_samples.push_back(sample_t'(acc));
      expected_lasts.push_back(it.last_in);
    endfunction

    function void check_output(sample_t s, logic l);
      sample_t want_s;
      logic    want_l;
      if (expected_samples.size() == 0) begin
        $error("unexpected output sample %0d", s);
        mismatches++;
        return;
      end
      want_s = expected_samples.pop_front();
      want_l = expected_lasts.pop_front();
      samples_checked++;
      if (s !== want_s) begin
        $error("sample_out: expected %0d, actual %0d", want_s, s);
        mismatches++;
      end
      if (l !== want_l) begin
        $error("last_out: expected %0b, actual %0b", want_l, l);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  swf_in_if  in_if();
  swf_out_if out_if();

  waveshaper_predictor net_model;
  int send_idle_pct;
  int recv_stall_pct;

  siren_mlp_waveshaper_core DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous cap on the whole run.
  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Output side: check each transfer, then pick the next ready at random.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_if.valid && out_if.ready)
        net_model.check_output(out_if.sample_out, out_if.last_out);
      out_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One input transfer; valid stays high into the next item unless it idles.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= it.kind;
    in_if.table_select <= it.table_select;
    in_if.entry_index  <= it.entry_index;
    in_if.weight_value <= it.weight_value;
    in_if.sample_in    <= it.sample_in;
    in_if.last_in      <= it.last_in;
    do @(posedge clk); while (!in_if.ready);
    net_model.note_input(it);
  endtask

  task automatic write_entry(logic [2:0] sel, int e, int w);
    in_item_t it;
    it.kind         = KIND_WRITE;
    it.table_select = sel;
    it.entry_index  = INDEX_W'(e);
    it.weight_value = IN_W_W'(w);
    it.sample_in    = sample_t'($urandom);
    it.last_in      = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_sample(int x, logic l);
    in_item_t it;
    it.kind         = KIND_SAMPLE;
    it.table_select = 3'($urandom);
    it.entry_index  = INDEX_W'($urandom);
    it.weight_value = IN_W_W'($urandom);
    it.sample_in    = sample_t'(x);
    it.last_in      = l;
    send_item(it);
  endtask

  // Mostly modest coefficients keep the sums in range; some span the full field.
  function automatic int pick_weight();
    if ($urandom_range(99) < 15)
      return int'(IN_W_W'($signed($urandom)));
    return $urandom_range(4096) - 2048;
  endfunction

  // Setup cycle, then access cycle; the register takes the value at the end of the access cycle.
  task automatic write_scale(logic [1:0] idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    net_model.set_scale(idx, scale_t'(value));
  endtask

  // Stop offering items, wait for outstanding samples, then let trailing writes retire.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (net_model.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_tables();
    for (int e = 0; e < HIDDEN_UNITS; e++) begin
      write_entry(TBL_IN_W, e, pick_weight());
      write_entry(TBL_IN_B, e, pick_weight());
      write_entry(TBL_MID_B, e, pick_weight());
      write_entry(TBL_UP_B, e, pick_weight());
      write_entry(TBL_OUT_W, e, pick_weight());
    end
    for (int e = 0; e < MAT_N; e++) begin
      write_entry(TBL_MID_W, e, pick_weight());
      write_entry(TBL_UP_W, e, pick_weight());
    end
    write_entry(TBL_OUT_B, 0, pick_weight());
  endtask

  // Short directed run: field extremes and writes that fall outside a table.
  task automatic directed_items();
    write_entry(TBL_IN_W, 0, 131071);
    write_entry(TBL_IN_W, 1, -131072);
    write_entry(TBL_MID_W, MAT_N - 1, -131072);
    write_entry(TBL_UP_W, MAT_N - 1, 131071);
    send_sample(0, 1'b0);
    send_sample(8388607, 1'b1);
    send_sample(-8388608, 1'b0);
    send_sample(1, 1'b1);
    send_sample(-1, 1'b0);
    write_entry(TBL_IN_B, HIDDEN_UNITS, 131071);
    write_entry(TBL_MID_B, MAT_N - 1, -131072);
    write_entry(TBL_UP_B, HIDDEN_UNITS, 77);
    write_entry(TBL_OUT_W, MAT_N - 1, 131071);
    write_entry(TBL_IN_W, HIDDEN_UNITS + 5, 131071);
    write_entry(TBL_OUT_B, 1, 131071);
    write_entry(TBL_OUT_B, MAT_N - 1, -131072);
    send_sample(8388607, 1'b1);
    write_entry(TBL_OUT_B, 0, -131072);
    send_sample(-8388608, 1'b1);
    write_entry(TBL_OUT_B, 0, 131071);
    send_sample(4194304, 1'b0);
  endtask

  task automatic random_items(int count);
    logic [2:0] sel;
    int         e;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(999) < 35) begin
        send_sample(int'(sample_t'($urandom)), 1'($urandom));
      end else begin
        sel = 3'($urandom);
        // Vector tables: mostly valid rows, sometimes any index.
        if (sel == TBL_MID_W || sel == TBL_UP_W || $urandom_range(9) == 0)
          e = $urandom_range(MAT_N - 1);
        else if (sel == TBL_OUT_B)
          e = 0;
        else
          e = $urandom_range(HIDDEN_UNITS - 1);
        write_entry(sel, e, pick_weight());
      end
    end
  endtask

  task automatic apply_setting(int setting);
    int s1, s2, s3;
    case (setting)
      0: begin s1 = 8388607;  s2 = -8388608; s3 = 8388607;  end
      1: begin s1 = -8388608; s2 = 8388607;  s3 = -8388608; end
      2: begin s1 = 0;        s2 = 312911;   s3 = 0;        end
      default: begin
        s1 = $urandom_range(2000000) - 1000000;
        s2 = $urandom_range(2000000) - 1000000;
        s3 = $urandom_range(2000000) - 1000000;
      end
    endcase
    write_scale(REG_FIRST, s1);
    write_scale(REG_SECOND, s2);
    write_scale(REG_THIRD, s3);
  endtask

  initial begin
    net_model = new();
    send_idle_pct  = 25;
    recv_stall_pct = 82;
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_WRITE;
    in_if.table_select = '0;
    in_if.entry_index  = '0;
    in_if.weight_value = '0;
    in_if.sample_in    = '0;
    in_if.last_in      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every table is filled before the first sample reads it.
    load_tables();
    directed_items();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 25; recv_stall_pct = 82; end
        1: begin send_idle_pct = 82; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        drain();
        apply_setting(phase * 2 + sub);
        random_items(350);
      end
    end
    drain();

    $display("Checked %0d output samples after %0d coefficient writes,",
             net_model.samples_checked, net_model.writes_seen);
    $display("over six phase scale settings and three idle patterns.");
    if (net_model.mismatches == 0 && net_model.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: siren_mlp_waveshaper_core.f
rtl/swf_pkg.sv
rtl/swf_in_if.sv
rtl/swf_out_if.sv
rtl/swf_front.sv
rtl/swf_sine.sv
rtl/swf_back.sv
rtl/siren_mlp_waveshaper_core.sv
sim/siren_mlp_waveshaper_core_test_if.sv
sim/siren_mlp_waveshaper_core_test.sv
